/* hw/rtl/wcag_contrast_ratio_unit_macros.svh */
// Assertion macros used by the checker.
`ifndef WCAG_CONTRAST_RATIO_UNIT_MACROS_SVH
`define WCAG_CONTRAST_RATIO_UNIT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define WCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same, but also checked during reset.
`define WCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hw/rtl/wcr_pkg.sv */
package wcr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CH_W      = 8;
    localparam int LUM_W     = FRAC_BITS + 1;
    localparam int RAT_W     = FRAC_BITS + 5;
    localparam int PROD_W    = 2 * LUM_W;
    localparam int SUM_W     = PROD_W + 2;

    localparam longint ONE      = longint'(1) << FRAC_BITS;
    localparam longint COEF_R_L = (2126 * ONE + 5000) / 10000;
    localparam longint COEF_B_L = (722 * ONE + 5000) / 10000;
    localparam longint COEF_G_L = ONE - COEF_R_L - COEF_B_L;
    localparam longint OFF_L    = (5 * ONE + 50) / 100;
    localparam longint KNEE_DIV = 329460;

    localparam logic [LUM_W-1:0] COEF_R = LUM_W'(COEF_R_L);
    localparam logic [LUM_W-1:0] COEF_G = LUM_W'(COEF_G_L);
    localparam logic [LUM_W-1:0] COEF_B = LUM_W'(COEF_B_L);
    localparam logic [LUM_W-1:0] LUM_OFF = LUM_W'(OFF_L);
    localparam logic [SUM_W-1:0] LUM_RND = SUM_W'(ONE >> 1);

    // stages: 3 in the lanes, 1 ordering stage, RAT_W quotient stages
    localparam int LANE_LAT = 3;
    localparam int PIPE_LAT = LANE_LAT + 1 + RAT_W;

    typedef logic [LUM_W-1:0] t_lum;
    typedef logic [CH_W-1:0]  t_chan;
    typedef t_lum t_lin_tbl [2**CH_W];

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    // sRGB byte to linear light, Q1.FRAC_BITS, rounded half up
    function automatic t_lin_tbl lin_tbl_build();
        t_lin_tbl t;
        real      y;
        longint   k;
        for (int v = 0; v < 2**CH_W; v++) begin
            if (v <= 10) begin
                k = ((longint'(v) * 100 * ONE) + KNEE_DIV / 2) / KNEE_DIV;
            end else begin
                y = (1000.0 * v + 14025.0) / 269025.0;
                k = longint'($floor($pow(y, 2.4) * (2.0 ** FRAC_BITS) + 0.5));
            end
            t[v] = LUM_W'(k);
        end
        return t;
    endfunction

    localparam t_lin_tbl LIN_TBL = lin_tbl_build();

endpackage

/* hw/rtl/wcr_if.sv */
interface wcr_in_if;
    import wcr_pkg::*;
    logic  valid;
    logic  ready;
    t_chan a_red;
    t_chan a_green;
    t_chan a_blue;
    t_chan b_red;
    t_chan b_green;
    t_chan b_blue;
    modport source (output valid, a_red, a_green, a_blue, b_red, b_green, b_blue,
                    input ready);
    modport sink (input valid, a_red, a_green, a_blue, b_red, b_green, b_blue,
                  output ready);
endinterface

interface wcr_out_if;
    import wcr_pkg::*;
    logic              valid;
    logic              ready;
    t_lum              lum_a;
    t_lum              lum_b;
    logic [RAT_W-1:0]  ratio;
    modport source (output valid, lum_a, lum_b, ratio, input ready);
    modport sink (input valid, lum_a, lum_b, ratio, output ready);
endinterface

/* hw/rtl/wcr_lum_lane.sv */
module wcr_lum_lane (
    input  logic          i_clk,
    input  logic          i_en,
    input  wcr_pkg::t_rgb i_rgb,
    output wcr_pkg::t_lum o_lum
);
    import wcr_pkg::*;

    t_lum             r_lin_r, r_lin_g, r_lin_b;
    logic [PROD_W-1:0] r_pr, r_pg, r_pb;
    t_lum             r_lum;
    logic [SUM_W-1:0] n_sum;

    assign n_sum = SUM_W'(r_pr) + SUM_W'(r_pg) + SUM_W'(r_pb) + LUM_RND;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lin_r <= LIN_TBL[i_rgb.red];
            r_lin_g <= LIN_TBL[i_rgb.green];
            r_lin_b <= LIN_TBL[i_rgb.blue];
            r_pr    <= r_lin_r * COEF_R;
            r_pg    <= r_lin_g * COEF_G;
            r_pb    <= r_lin_b * COEF_B;
            r_lum   <= n_sum[FRAC_BITS +: LUM_W];
        end
    end

    assign o_lum = r_lum;
endmodule

/* hw/rtl/wcr_divider.sv */
// Orders the two luminances and divides one quotient bit per stage.
module wcr_divider (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  wcr_pkg::t_lum             i_lum_a,
    input  wcr_pkg::t_lum             i_lum_b,
    output wcr_pkg::t_lum             o_lum_a,
    output wcr_pkg::t_lum             o_lum_b,
    output logic [wcr_pkg::RAT_W-1:0] o_ratio
);
    import wcr_pkg::*;

    localparam int SH = RAT_W - FRAC_BITS;

    t_lum             r_rem  [RAT_W+1];
    t_lum             r_div  [RAT_W+1];
    logic [RAT_W-1:0] r_nlo  [RAT_W+1];
    logic [RAT_W-1:0] r_q    [RAT_W+1];
    t_lum             r_la   [RAT_W+1];
    t_lum             r_lb   [RAT_W+1];

    t_lum n_hi, n_lo;

    always_comb begin
        if (i_lum_a > i_lum_b) begin
            n_hi = i_lum_a + LUM_OFF;
            n_lo = i_lum_b + LUM_OFF;
        end else begin
            n_hi = i_lum_b + LUM_OFF;
            n_lo = i_lum_a + LUM_OFF;
        end
    end

    // dividend is hi << FRAC_BITS; its top part seeds the remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_hi >> SH;
            r_div[0] <= n_lo;
            r_nlo[0] <= {n_hi[SH-1:0], {FRAC_BITS{1'b0}}};
            r_q[0]   <= '0;
            r_la[0]  <= i_lum_a;
            r_lb[0]  <= i_lum_b;
        end
    end

    for (genvar i = 0; i < RAT_W; i++) begin : g_stage
        logic [LUM_W:0] rem2;
        logic           ge;
        assign rem2 = {r_rem[i], r_nlo[i][RAT_W-1]};
        assign ge   = rem2 >= {1'b0, r_div[i]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i+1] <= ge ? LUM_W'(rem2 - {1'b0, r_div[i]}) : rem2[LUM_W-1:0];
                r_div[i+1] <= r_div[i];
                r_nlo[i+1] <= r_nlo[i] << 1;
                r_q[i+1]   <= {r_q[i][RAT_W-2:0], ge};
                r_la[i+1]  <= r_la[i];
                r_lb[i+1]  <= r_lb[i];
            end
        end
    end

    assign o_lum_a = r_la[RAT_W];
    assign o_lum_b = r_lb[RAT_W];
    assign o_ratio = r_q[RAT_W];
endmodule

/* hw/rtl/wcag_contrast_ratio_unit.sv */
// WCAG 2.1 contrast ratio of two sRGB colors. A new color pair is taken every
// cycle while the pipeline is not stalled, and passes through 3 lane stages of
// table lookup, multiply and sum, one ordering stage, then one stage per quotient
// bit of the 21-bit divider. The pipeline stalls as a whole only while the final
// result is held unaccepted. Luminances are Q1.16, the ratio is Q5.16, floored.
module wcag_contrast_ratio_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wcr_in_if.sink     i_pix,
    wcr_out_if.source  o_res
);
    import wcr_pkg::*;

    logic              w_en;
    logic [PIPE_LAT-1:0] r_vld;
    t_lum              w_la, w_lb;
    t_rgb              w_rgb_a, w_rgb_b;

    assign w_en        = !r_vld[PIPE_LAT-1] || o_res.ready;
    assign i_pix.ready = w_en;
    assign w_rgb_a     = '{red: i_pix.a_red, green: i_pix.a_green, blue: i_pix.a_blue};
    assign w_rgb_b     = '{red: i_pix.b_red, green: i_pix.b_green, blue: i_pix.b_blue};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_pix.valid};
        end
    end

    wcr_lum_lane u_lane_a (.i_clk(i_clk), .i_en(w_en), .i_rgb(w_rgb_a), .o_lum(w_la));
    wcr_lum_lane u_lane_b (.i_clk(i_clk), .i_en(w_en), .i_rgb(w_rgb_b), .o_lum(w_lb));

    wcr_divider u_div (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_lum_a (w_la),
        .i_lum_b (w_lb),
        .o_lum_a (o_res.lum_a),
        .o_lum_b (o_res.lum_b),
        .o_ratio (o_res.ratio)
    );

    assign o_res.valid = r_vld[PIPE_LAT-1];
endmodule

/* hw/rtl/wcr_checker.sv */
`include "wcag_contrast_ratio_unit_macros.svh"

module wcr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      i_ready,
    input wcr_pkg::t_lum             i_lum_a,
    input wcr_pkg::t_lum             i_lum_b,
    input logic [wcr_pkg::RAT_W-1:0] i_ratio
);
    import wcr_pkg::*;

    localparam logic [RAT_W-1:0] RAT_ONE = RAT_W'(ONE);

    // a stalled transaction stays put
    `WCR_ASSERT(a_hold, i_valid && !i_ready |=> i_valid && $stable(i_ratio), "result dropped under stall")
    `WCR_ASSERT(a_min, i_valid |-> i_ratio >= RAT_ONE, "ratio below one")
    `WCR_ASSERT(a_equal, i_valid && i_lum_a == i_lum_b |-> i_ratio == RAT_ONE, "equal colors not one")
    `WCR_ASSERT(a_order, i_valid && i_lum_a != i_lum_b |-> i_ratio > RAT_ONE || i_lum_a + 1 == i_lum_b || i_lum_b + 1 == i_lum_a, "ratio too low for distinct luminances")
endmodule

bind wcag_contrast_ratio_unit wcr_checker u_wcr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_lum_a (o_res.lum_a),
    .i_lum_b (o_res.lum_b),
    .i_ratio (o_res.ratio)
);
